@@ rtl/udp_port_packet_steer_unit_defines.svh @@
// Assertion macros for the UDP port packet steering unit.
// Included by the top level; the bodies vanish when SYNTH is defined.
`ifndef UDP_PORT_PACKET_STEER_UNIT_DEFINES_SVH
`define UDP_PORT_PACKET_STEER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define UPPS_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("upps assertion failed");
`define UPPS_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("upps assertion failed");
`else
`define UPPS_ASSERT_IMPL(label, clk, rst, a, b)
`define UPPS_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

@@ rtl/udp_pps_pkg.sv @@
// Package for the UDP port packet steering unit: item types, register
// indexes, verdict reason codes and header constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package udp_pps_pkg;

  localparam int PORT_SLOTS_MAX  = 16;
  localparam int QUEUE_COUNT_MAX = 64;
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_PORTS_0    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOT_MASK  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_QUEUE_MASK = 3'd5;

  localparam logic [2:0] WHY_REDIRECT  = 3'd0;
  localparam logic [2:0] WHY_SHORT     = 3'd1;
  localparam logic [2:0] WHY_NOT_IPV4  = 3'd2;
  localparam logic [2:0] WHY_NOT_UDP   = 3'd3;
  localparam logic [2:0] WHY_UNLISTED  = 3'd4;
  localparam logic [2:0] WHY_NO_SOCKET = 3'd5;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
  localparam logic [7:0]  IDX_TYPE_HI    = 8'd12;
  localparam logic [7:0]  IDX_TYPE_LO    = 8'd13;
  localparam logic [7:0]  IDX_IHL        = 8'd14;
  localparam logic [7:0]  IDX_PROTO      = 8'd23;
  localparam logic [7:0]  IDX_MIN_IP     = 8'd33;
  localparam logic [7:0]  UDP_END_OFFSET = 8'd7;
  localparam logic [7:0]  BYTE_COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic [5:0] rx_queue;
  } in_item_t;

  typedef struct packed {
    logic       verdict;
    logic [5:0] out_queue;
    logic [2:0] why;
  } out_item_t;

  typedef struct packed {
    logic port_hit;
    logic socket_bound;
  } lookup_t;

endpackage

`default_nettype wire

@@ rtl/udp_port_packet_steer_unit.sv @@
// A final byte passes through the input register, then the result register, which
// presents its verdict on out_valid.
// Throughput: one frame byte per cycle; the input register drains while a
// verdict waits, and stalls only when it holds a final byte and the result
// register is still full. Reset clears all configuration and frame state.
`timescale 1ns / 1ps
`default_nettype none
`include "udp_port_packet_steer_unit_defines.svh"

module udp_port_packet_steer_unit #(
  parameter int PORT_SLOTS  = udp_pps_pkg::PORT_SLOTS_MAX,
  parameter int QUEUE_COUNT = udp_pps_pkg::QUEUE_COUNT_MAX
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire udp_pps_pkg::in_item_t               in_item,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output udp_pps_pkg::out_item_t                   out_item,
  input  wire logic                                cfg_we,
  input  wire logic [udp_pps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [udp_pps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                   hold_valid;
  udp_pps_pkg::in_item_t  hold_item;
  logic                   hold_adv;
  logic                   out_load;
  logic                   out_free;
  logic [15:0]            dest_port;
  udp_pps_pkg::lookup_t   lookup;
  udp_pps_pkg::out_item_t result;

  assign out_free = !out_valid || out_ready;
  assign hold_adv = hold_valid && (!hold_item.frame_end || out_free);
  assign in_ready = !hold_valid || hold_adv;
  assign out_load = hold_adv && hold_item.frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= result;
    end
  end

  udp_pps_cfg_regs #(
    .PORT_SLOTS  (PORT_SLOTS),
    .QUEUE_COUNT (QUEUE_COUNT)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dest_port (dest_port),
    .rx_queue  (hold_item.rx_queue),
    .lookup    (lookup)
  );

  udp_pps_frame_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (hold_adv),
    .item      (hold_item),
    .lookup    (lookup),
    .dest_port (dest_port),
    .result    (result)
  );

  `UPPS_ASSERT_IMPL(a_verdict_matches_why, clk, rst, out_valid, out_item.verdict == (out_item.why == udp_pps_pkg::WHY_REDIRECT))
  `UPPS_ASSERT_IMPL(a_why_in_range, clk, rst, out_valid, out_item.why <= udp_pps_pkg::WHY_NO_SOCKET)
  `UPPS_ASSERT_NEXT(a_final_byte_gives_result, clk, rst, out_load, out_valid)
  `UPPS_ASSERT_IMPL(a_stall_only_on_final, clk, rst, !in_ready, hold_valid && hold_item.frame_end && !out_free)

endmodule

`default_nettype wire

@@ rtl/udp_pps_cfg_regs.sv @@
// Configuration registers of the steering unit and the port and socket lookups
// that read them. Depends on udp_pps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module udp_pps_cfg_regs #(
  parameter int PORT_SLOTS  = udp_pps_pkg::PORT_SLOTS_MAX,
  parameter int QUEUE_COUNT = udp_pps_pkg::QUEUE_COUNT_MAX
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [udp_pps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [udp_pps_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [15:0]                         dest_port,
  input  wire logic [5:0]                          rx_queue,
  output udp_pps_pkg::lookup_t                     lookup
);

  logic [15:0]                          port_tab [PORT_SLOTS];
  logic [PORT_SLOTS-1:0]                slot_mask;
  logic [QUEUE_COUNT-1:0]               queue_mask;
  logic [PORT_SLOTS-1:0]                slot_hit;
  logic [udp_pps_pkg::QUEUE_COUNT_MAX-1:0] queue_mask_ext;

  for (genvar s = 0; s < PORT_SLOTS; s++) begin : g_slot
    localparam logic [udp_pps_pkg::CFG_INDEX_W-1:0] RIDX =
      udp_pps_pkg::REG_PORTS_0 + udp_pps_pkg::CFG_INDEX_W'(s / 4);
    localparam int LSB = (s % 4) * 16;

    always_ff @(posedge clk) begin
      if (rst) begin
        port_tab[s] <= '0;
      end else if (cfg_we && cfg_index == RIDX) begin
        port_tab[s] <= cfg_data[LSB +: 16];
      end
    end

    assign slot_hit[s] = slot_mask[s] && (port_tab[s] == dest_port);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_mask  <= '0;
      queue_mask <= '0;
    end else if (cfg_we) begin
      if (cfg_index == udp_pps_pkg::REG_SLOT_MASK) begin
        slot_mask <= cfg_data[PORT_SLOTS-1:0];
      end
      if (cfg_index == udp_pps_pkg::REG_QUEUE_MASK) begin
        queue_mask <= cfg_data[QUEUE_COUNT-1:0];
      end
    end
  end

  // Queues beyond the configured count read as having no socket bound.
  assign queue_mask_ext      = udp_pps_pkg::QUEUE_COUNT_MAX'(queue_mask);
  assign lookup.port_hit     = |slot_hit;
  assign lookup.socket_bound = queue_mask_ext[rx_queue];

endmodule

`default_nettype wire

@@ rtl/udp_pps_frame_parser.sv @@
// Per-frame header capture and the verdict for the final byte of a frame.
// Depends on udp_pps_pkg; port and socket lookups come from udp_pps_cfg_regs.
`timescale 1ns / 1ps
`default_nettype none

module udp_pps_frame_parser (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire udp_pps_pkg::in_item_t  item,
  input  wire udp_pps_pkg::lookup_t   lookup,
  output logic [15:0]                 dest_port,
  output udp_pps_pkg::out_item_t      result
);

  logic [7:0]  byte_count;
  logic [15:0] ether_type;
  logic [7:0]  ip_protocol;
  logic [3:0]  header_words;

  logic [15:0] ether_type_next;
  logic [7:0]  ip_protocol_next;
  logic [3:0]  header_words_next;
  logic [15:0] dest_port_next;
  logic [7:0]  udp_start;
  logic [7:0]  byte_count_next;

  always_comb begin
    ether_type_next = ether_type;
    if (byte_count == udp_pps_pkg::IDX_TYPE_HI) begin
      ether_type_next[15:8] = item.frame_byte;
    end else if (byte_count == udp_pps_pkg::IDX_TYPE_LO) begin
      ether_type_next[7:0] = item.frame_byte;
    end

    header_words_next = (byte_count == udp_pps_pkg::IDX_IHL) ?
                        item.frame_byte[3:0] : header_words;
    ip_protocol_next  = (byte_count == udp_pps_pkg::IDX_PROTO) ?
                        item.frame_byte : ip_protocol;

    udp_start = udp_pps_pkg::ETH_HDR_LEN + {2'b00, header_words_next, 2'b00};

    dest_port_next = dest_port;
    if (byte_count == udp_start + 8'd2) begin
      dest_port_next[15:8] = item.frame_byte;
    end else if (byte_count == udp_start + 8'd3) begin
      dest_port_next[7:0] = item.frame_byte;
    end

    byte_count_next = (byte_count == udp_pps_pkg::BYTE_COUNT_MAX) ?
                      byte_count : byte_count + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      ether_type   <= '0;
      ip_protocol  <= '0;
      header_words <= '0;
      dest_port    <= '0;
    end else if (step) begin
      if (item.frame_end) begin
        byte_count   <= '0;
        ether_type   <= '0;
        ip_protocol  <= '0;
        header_words <= '0;
        dest_port    <= '0;
      end else begin
        byte_count   <= byte_count_next;
        ether_type   <= ether_type_next;
        ip_protocol  <= ip_protocol_next;
        header_words <= header_words_next;
        dest_port    <= dest_port_next;
      end
    end
  end

  // The port lookup uses the stored port. A final byte that still changes the
  // port leaves the UDP header incomplete, so that frame is too short anyway.
  // Length checks are written against the byte index, which is length less one.
  always_comb begin
    result.out_queue = item.rx_queue;
    result.verdict   = 1'b0;
    if (byte_count < udp_pps_pkg::IDX_TYPE_LO) begin
      result.why = udp_pps_pkg::WHY_SHORT;
    end else if (ether_type_next != udp_pps_pkg::ETHERTYPE_IPV4) begin
      result.why = udp_pps_pkg::WHY_NOT_IPV4;
    end else if (byte_count < udp_pps_pkg::IDX_MIN_IP) begin
      result.why = udp_pps_pkg::WHY_SHORT;
    end else if (ip_protocol_next != udp_pps_pkg::PROTO_UDP) begin
      result.why = udp_pps_pkg::WHY_NOT_UDP;
    end else if (byte_count < udp_start + udp_pps_pkg::UDP_END_OFFSET) begin
      result.why = udp_pps_pkg::WHY_SHORT;
    end else if (!lookup.port_hit) begin
      result.why = udp_pps_pkg::WHY_UNLISTED;
    end else if (!lookup.socket_bound) begin
      result.why = udp_pps_pkg::WHY_NO_SOCKET;
    end else begin
      result.why     = udp_pps_pkg::WHY_REDIRECT;
      result.verdict = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ verif/udp_pps_checker.sv @@
// Checker for the UDP port packet steering unit: tracks register writes and
// frame bytes, predicts each verdict and compares it with the output channel.
// Depends on udp_pps_pkg for the item types, register indexes and codes.
`timescale 1ns / 1ps

module udp_pps_checker
  import udp_pps_pkg::*;
#(
  parameter int PORT_SLOTS  = PORT_SLOTS_MAX,
  parameter int QUEUE_COUNT = QUEUE_COUNT_MAX
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_item,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     verdicts_waiting,
  output int                     verdicts_checked,
  output int                     redirects_seen
);

  localparam int MIN_IPV4_FRAME   = 34;
  localparam int UDP_HEADER_BYTES = 8;
  localparam int DEST_PORT_OFFSET = 2;

  logic [63:0] port_word [4];
  logic [15:0] redirect_slots;
  logic [63:0] socket_queues;

  logic [7:0]  seen_bytes;
  logic [15:0] cur_ether_type;
  logic [7:0]  cur_protocol;
  logic [3:0]  cur_ihl;
  logic [15:0] cur_dest_port;

  out_item_t expected_verdicts [$];

  initial begin
    mismatches       = 0;
    verdicts_checked = 0;
    redirects_seen   = 0;
    verdicts_waiting = 0;
  end

  // Only slots with their redirect bit set can match; duplicates are harmless.
  function automatic logic port_is_listed(input logic [15:0] port);
    logic hit;
    hit = 1'b0;
    for (int s = 0; s < PORT_SLOTS && s < PORT_SLOTS_MAX; s++) begin
      if (port_word[s / 4][(s % 4) * 16 +: 16] == port && redirect_slots[s]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic out_item_t judge_frame(input int frame_len, input int udp_start,
                                            input logic [5:0] queue);
    out_item_t v;
    v.verdict   = 1'b0;
    v.out_queue = queue;
    if (frame_len < int'(ETH_HDR_LEN)) begin
      v.why = WHY_SHORT;
    end else if (cur_ether_type != ETHERTYPE_IPV4) begin
      v.why = WHY_NOT_IPV4;
    end else if (frame_len < MIN_IPV4_FRAME) begin
      v.why = WHY_SHORT;
    end else if (cur_protocol != PROTO_UDP) begin
      v.why = WHY_NOT_UDP;
    end else if (frame_len < udp_start + UDP_HEADER_BYTES) begin
      v.why = WHY_SHORT;
    end else if (!port_is_listed(cur_dest_port)) begin
      v.why = WHY_UNLISTED;
    end else if (int'(queue) >= QUEUE_COUNT || !socket_queues[queue]) begin
      v.why = WHY_NO_SOCKET;
    end else begin
      v.why     = WHY_REDIRECT;
      v.verdict = 1'b1;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    int        idx;
    int        udp_start;
    int        frame_len;
    logic [7:0] b;
    out_item_t want;

    if (rst) begin
      for (int w = 0; w < 4; w++) port_word[w] = '0;
      redirect_slots = '0;
      socket_queues  = '0;
      seen_bytes     = '0;
      cur_ether_type = '0;
      cur_protocol   = '0;
      cur_ihl        = '0;
      cur_dest_port  = '0;
      expected_verdicts.delete();
    end else begin
      // Pop before pushing, so a verdict that appears with no expectation
      // waiting is never matched against one queued at the same edge.
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected verdict: verdict %0d queue %0d why %0d",
                     out_item.verdict, out_item.out_queue, out_item.why);
          end
        end else begin
          want = expected_verdicts.pop_front();
          verdicts_checked++;
          if (out_item.verdict) redirects_seen++;
          if (out_item.verdict !== want.verdict || out_item.out_queue !== want.out_queue ||
              out_item.why !== want.why) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("verdict mismatch: expected verdict %0d queue %0d why %0d, got %0d %0d %0d",
                       want.verdict, want.out_queue, want.why,
                       out_item.verdict, out_item.out_queue, out_item.why);
            end
          end
        end
      end

      if (in_valid && in_ready) begin
        idx = int'(seen_bytes);
        b   = in_item.frame_byte;
        if (idx == int'(IDX_TYPE_HI)) begin
          cur_ether_type[15:8] = b;
        end else if (idx == int'(IDX_TYPE_LO)) begin
          cur_ether_type[7:0] = b;
        end
        if (idx == int'(IDX_IHL)) cur_ihl = b[3:0];
        // The UDP header may start inside the IPv4 header when IHL is below five.
        udp_start = int'(ETH_HDR_LEN) + 4 * int'(cur_ihl);
        if (idx == int'(IDX_PROTO)) cur_protocol = b;
        if (idx >= 16 && idx == udp_start + DEST_PORT_OFFSET) begin
          cur_dest_port[15:8] = b;
        end else if (idx >= 17 && idx == udp_start + DEST_PORT_OFFSET + 1) begin
          cur_dest_port[7:0] = b;
        end
        if (seen_bytes != BYTE_COUNT_MAX) seen_bytes = seen_bytes + 8'd1;

        if (in_item.frame_end) begin
          frame_len = (idx + 1 > int'(BYTE_COUNT_MAX)) ? int'(BYTE_COUNT_MAX) : idx + 1;
          expected_verdicts.push_back(judge_frame(frame_len, udp_start, in_item.rx_queue));
          seen_bytes     = '0;
          cur_ether_type = '0;
          cur_protocol   = '0;
          cur_ihl        = '0;
          cur_dest_port  = '0;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_SLOT_MASK:  redirect_slots = cfg_data[15:0];
          REG_QUEUE_MASK: socket_queues  = cfg_data;
          default: begin
            if (cfg_index >= REG_PORTS_0 && cfg_index < REG_SLOT_MASK) begin
              port_word[cfg_index - REG_PORTS_0] = cfg_data;
            end
          end
        endcase
      end
    end
    verdicts_waiting <= expected_verdicts.size();
  end

endmodule

@@ verif/testbench.sv @@
// Top of the steering unit testbench: clock, reset, register plans, frame
// stimulus and output back-pressure, with the verdict given at the end.
// Depends on udp_pps_pkg, udp_port_packet_steer_unit and udp_pps_checker.
`timescale 1ns / 1ps

module testbench;
  import udp_pps_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_BYTES    = 80;
  localparam int PHASE_FRAMES   = 2;

  typedef enum int {
    PLAN_DIRECTED,
    PLAN_RANDOM,
    PLAN_DUPLICATES,
    PLAN_ALL_ONES,
    PLAN_ZERO_PORTS,
    PLAN_SPARSE
  } reg_plan_e;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_item;
  logic                   out_valid;
  logic                   out_ready;
  out_item_t              out_item;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatches;
  int verdicts_waiting;
  int verdicts_checked;
  int redirects_seen;

  // Copy of what has been programmed, used to aim frames at listed ports.
  logic [15:0] slot_port [16];
  logic [15:0] slot_mask;
  logic [63:0] queue_mask;

  logic [7:0] frame_buf [$];
  logic       bursts_on;
  logic       hold_req;
  int         bytes_sent;
  int         frames_sent;
  int         settings_loaded;

  udp_port_packet_steer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  udp_pps_checker verdict_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_item),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .verdicts_waiting (verdicts_waiting),
    .verdicts_checked (verdicts_checked),
    .redirects_seen   (redirects_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("udp_port_packet_steer_unit verification failed");
    $finish;
  end

  // Output side: random stalls, plain stretches, and one long hold-off.
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic plan_registers(input reg_plan_e plan);
    for (int s = 0; s < 16; s++) slot_port[s] = 16'($urandom);
    slot_mask  = 16'($urandom);
    queue_mask = {$urandom, $urandom};
    case (plan)
      PLAN_DIRECTED: begin
        for (int s = 0; s < 16; s++) slot_port[s] = 16'h1000 + 16'(s);
        slot_port[0]  = 16'h0000;
        slot_port[15] = 16'hFFFF;
        // Same port in two slots, only the second one enabled.
        slot_port[3]  = 16'h2222;
        slot_port[7]  = 16'h2222;
        slot_port[9]  = 16'h3333;
        slot_mask     = 16'hFFFF & ~16'h0208;
        queue_mask    = ~64'h20;
      end
      PLAN_DUPLICATES: begin
        for (int s = 0; s < 16; s++) slot_port[s] = 16'h5000 + 16'($urandom_range(0, 3));
      end
      PLAN_ALL_ONES: begin
        for (int s = 0; s < 16; s++) slot_port[s] = 16'hFFFF;
        slot_mask  = 16'hFFFF;
        queue_mask = '1;
      end
      PLAN_ZERO_PORTS: begin
        for (int s = 0; s < 16; s++) slot_port[s] = 16'h0000;
        slot_mask  = 16'hFFFF;
        queue_mask = '1;
      end
      PLAN_SPARSE: begin
        slot_mask  = 16'h1 << $urandom_range(0, 15);
        queue_mask = 64'h1 << $urandom_range(0, 63);
      end
      default: ;
    endcase
  endtask

  // Called only with the unit idle; cfg_we drops in the step after the last write.
  task automatic load_registers();
    logic [63:0] word;
    int w;
    int k;
    for (w = 0; w < 4; w++) begin
      for (k = 0; k < 4; k++) word[16 * k +: 16] = slot_port[4 * w + k];
      cfg_we    <= 1'b1;
      cfg_index <= REG_PORTS_0 + 3'(w);
      cfg_data  <= word;
      @(posedge clk);
    end
    cfg_index <= REG_SLOT_MASK;
    cfg_data  <= {$urandom, 16'($urandom), slot_mask};
    @(posedge clk);
    cfg_index <= REG_QUEUE_MASK;
    cfg_data  <= queue_mask;
    @(posedge clk);
    // Indexes past the register list must leave everything untouched.
    cfg_index <= ($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI;
    cfg_data  <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  task automatic offer_byte(input logic [7:0] b, input logic last, input logic [5:0] queue);
    in_valid <= 1'b1;
    in_item  <= '{frame_byte: b, frame_end: last, rx_queue: queue};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (bursts_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [5:0] queue);
    for (int i = 0; i < frame_buf.size(); i++) begin
      offer_byte(frame_buf[i], i == frame_buf.size() - 1,
                 (i == frame_buf.size() - 1) ? queue : 6'($urandom));
    end
    frames_sent++;
  endtask

  // Random bytes with the header fields laid over them where the frame reaches.
  task automatic build_frame(input int len, input logic [15:0] etype, input logic [3:0] ihl,
                             input logic [7:0] proto, input logic [15:0] port);
    int udp_start;
    frame_buf.delete();
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
    udp_start = 14 + 4 * int'(ihl);
    if (len > 12) frame_buf[12] = etype[15:8];
    if (len > 13) frame_buf[13] = etype[7:0];
    if (len > 14) frame_buf[14] = {4'($urandom), ihl};
    if (len > 23) frame_buf[23] = proto;
    if (len > udp_start + 2) frame_buf[udp_start + 2] = port[15:8];
    if (len > udp_start + 3) frame_buf[udp_start + 3] = port[7:0];
  endtask

  task automatic udp_frame(input int len, input logic [3:0] ihl, input logic [15:0] port,
                           input logic [5:0] queue);
    build_frame(len, ETHERTYPE_IPV4, ihl, PROTO_UDP, port);
    send_frame(queue);
  endtask

  function automatic logic [15:0] pick_port();
    int s;
    s = $urandom_range(0, 15);
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom);
      2: return slot_port[s];
      default: begin
        if (slot_mask != 0) begin
          while (!slot_mask[s]) s = (s + 1) % 16;
        end
        return slot_port[s];
      end
    endcase
  endfunction

  function automatic logic [5:0] pick_queue();
    int q;
    q = $urandom_range(0, 63);
    if (queue_mask != 0 && $urandom_range(0, 9) < 7) begin
      while (!queue_mask[q]) q = (q + 1) % 64;
    end
    return 6'(q);
  endfunction

  task automatic send_random_frame();
    int kind;
    int ihl;
    int len;
    logic [15:0] etype;
    logic [7:0] proto;
    kind = $urandom_range(0, 99);
    ihl  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 5;
    len  = 14 + 4 * ihl + 8;
    if ($urandom_range(0, 3) != 0) len += $urandom_range(0, 24);
    if (len < 34) len = 34 + $urandom_range(0, 8);
    if (kind < 5) begin
      // One byte short of the UDP header, unless that is under the 34-byte IPv4 minimum.
      len = 14 + 4 * ihl + 7;
      if (len < 34) len = 34;
      udp_frame(len, 4'(ihl), pick_port(), pick_queue());
    end else if (kind < 70) begin
      udp_frame(len, 4'(ihl), pick_port(), pick_queue());
    end else if (kind < 78) begin
      etype = ($urandom_range(0, 1) == 0) ? ETHERTYPE_IPV4 ^ (16'h1 << $urandom_range(0, 15))
                                          : 16'($urandom);
      if (etype == ETHERTYPE_IPV4) etype = 16'h86DD;
      build_frame($urandom_range(14, 80), etype, 4'(ihl), PROTO_UDP, pick_port());
      send_frame(pick_queue());
    end else if (kind < 85) begin
      proto = 8'($urandom);
      if (proto == PROTO_UDP) proto = PROTO_UDP ^ (8'h1 << $urandom_range(0, 7));
      build_frame(len, ETHERTYPE_IPV4, 4'(ihl), proto, pick_port());
      send_frame(pick_queue());
    end else if (kind < 97) begin
      etype = ($urandom_range(0, 1) == 0) ? ETHERTYPE_IPV4 : 16'($urandom);
      build_frame($urandom_range(1, 40), etype, 4'(ihl), PROTO_UDP, pick_port());
      send_frame(6'($urandom));
    end else begin
      udp_frame($urandom_range(200, 300), 4'(ihl), pick_port(), pick_queue());
    end
  endtask

  // Stop offering and wait until every verdict owed has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int phase_bytes;
    int phase_frames;
    int waited;

    rst             <= 1'b1;
    in_valid        <= 1'b0;
    in_item         <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    bursts_on        = 1'b1;
    hold_req         = 1'b0;
    bytes_sent       = 0;
    frames_sent      = 0;
    settings_loaded  = 0;
    plan_registers(PLAN_ZERO_PORTS);
    slot_mask  = '0;
    queue_mask = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Short frames and a foreign EtherType, with registers as reset left them.
    udp_frame(1, 4'd5, 16'h0000, 6'd0);
    udp_frame(13, 4'd5, 16'h0000, 6'd63);
    udp_frame(14, 4'd5, 16'h0000, 6'd1);
    build_frame(14, 16'h86DD, 4'd5, PROTO_UDP, 16'h0000);
    send_frame(6'd2);

    settle();
    plan_registers(PLAN_DIRECTED);
    load_registers();
    udp_frame(33, 4'd5, 16'h1001, 6'd0);
    build_frame(34, ETHERTYPE_IPV4, 4'd5, 8'd6, 16'h1001);
    send_frame(6'd0);
    udp_frame(34, 4'd5, 16'h1001, 6'd0);
    udp_frame(41, 4'd5, 16'h1001, 6'd0);
    udp_frame(42, 4'd5, 16'h1001, 6'd0);
    // IHL below five puts the port inside the IPv4 header.
    udp_frame(34, 4'd0, 16'h0000, 6'd63);
    udp_frame(34, 4'd1, 16'hFFFF, 6'd0);
    udp_frame(81, 4'd15, 16'h1001, 6'd0);
    udp_frame(82, 4'd15, 16'h1001, 6'd0);
    udp_frame(42, 4'd5, 16'h2222, 6'd0);
    udp_frame(42, 4'd5, 16'h3333, 6'd0);
    udp_frame(42, 4'd5, 16'hABCD, 6'd0);
    udp_frame(42, 4'd5, 16'h1001, 6'd5);
    // Long frames take the byte counter to its limit, the longer one into saturation.
    udp_frame(255, 4'd5, 16'h1001, 6'd63);
    udp_frame(300, 4'd5, 16'h1001, 6'd0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: plan_registers(PLAN_RANDOM);
        1: plan_registers(PLAN_DUPLICATES);
        2: plan_registers(PLAN_ALL_ONES);
        3: plan_registers(PLAN_ZERO_PORTS);
        4: plan_registers(PLAN_SPARSE);
        default: plan_registers(PLAN_RANDOM);
      endcase
      load_registers();
      bursts_on    = (phase != 2) && (phase != RANDOM_PHASES - 1);
      phase_bytes  = bytes_sent;
      phase_frames = frames_sent;
      while (bytes_sent - phase_bytes < PHASE_BYTES || frames_sent - phase_frames < PHASE_FRAMES) begin
        send_random_frame();
      end
      if (phase == 1) begin
        // Hold the output off while tiny frames keep arriving, so the unit fills up.
        settle();
        bursts_on = 1'b0;
        hold_req  = 1'b1;
        for (int i = 0; i < 30; i++) begin
          build_frame($urandom_range(1, 3), 16'($urandom), 4'd5, PROTO_UDP, 16'h0000);
          send_frame(6'($urandom));
        end
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (verdicts_waiting != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);

    $display("Sent %0d frames (%0d bytes) across %0d register settings, with a %0d-cycle hold-off.",
             frames_sent, bytes_sent, settings_loaded, HOLD_CYCLES);
    $display("Compared %0d verdicts, %0d of them redirects; %0d mismatches, %0d still owed.",
             verdicts_checked, redirects_seen, mismatches, verdicts_waiting);
    if (mismatches == 0 && verdicts_waiting == 0) begin
      $display("udp_port_packet_steer_unit verification clean");
    end else begin
      $display("udp_port_packet_steer_unit verification failed");
    end
    $finish;
  end

endmodule
